@@ design/l3bs_pkg.sv @@
// Shared types and constants for the L3 bus byte serializer.
// Used by the register block, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package l3bs_pkg;

   // Configuration register map (register index = byte address / 4).
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [1:0]  REG_PHASE_HOLD = 2'd0;

   localparam logic [15:0] PHASE_HOLD_RESET = 16'd20;

   // Phase numbering within one transfer.
   localparam logic [4:0] PH_MODE_START   = 5'd0;
   localparam logic [4:0] PH_LAST_BIT     = 5'd16;
   localparam logic [4:0] PH_FINAL_CLOCK  = 5'd17;
   localparam logic [4:0] PH_ADDR_LAST    = 5'd18;
   localparam logic [4:0] PH_STROBE_LOW   = 5'd18;
   localparam logic [4:0] PH_DATA_LAST    = 5'd19;

   typedef enum logic {
      ACT_ADDRESS = 1'b0,
      ACT_DATA    = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic start;   // load a new byte and restart the phase count
      logic apply;   // drive the next phase onto the pins and the output beat
   } cmd_type;

   typedef struct packed {
      logic hold_done;  // the current phase has been held long enough
      logic out_empty;  // the output beat has been taken
      logic is_last;    // the phase just driven ends the transfer
   } status_type;

endpackage

@@ design/l3_bus_byte_serializer_unit.sv @@
// The first phase beat is registered: the accepting edge moves the controller into its apply state,
// which loads the first phase into the output register. Each phase is then held until the hold
// counter has expired and its beat has been taken. An address byte has 19 phases and a data byte 20.
// A new byte is taken only after the last phase of the previous one has been delivered and held.
// Reset (synchronous, active high) drives all three pin levels high, empties the output
// register and restores the phase hold time to 20.
`timescale 1ns / 1ps

module l3_bus_byte_serializer_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Input beats: one byte to transfer.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] byte_value
   input  logic                                req_tuser,   // [0] action
   // Result beats: one per pin phase.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // [0] mode_pin, [1] clock_pin,
                                                            // [2] data_pin, [7:3] zero
   output logic                                rsp_tlast,   // last_phase
   // Configuration port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [l3bs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [l3bs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [l3bs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import l3bs_pkg::*;

   // The controller and datapath talk only through these two bundles.
   cmd_type     cmd;
   status_type  status;
   logic [15:0] phase_hold;
   logic [2:0]  pins;

   // Register block: holds the hold time written over the configuration port.
   l3bs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .phase_hold  (phase_hold)
   );

   // Controller: waits for a byte, then alternates between driving a phase and holding it
   // until the hold time has elapsed and the phase beat has been taken downstream.
   l3bs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: the pin levels persist between transfers; each driven phase updates one or two of
   // them according to the phase count and copies all three into the output register.
   l3bs_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .phase_hold (phase_hold),
      .action     (req_tuser),
      .byte_value (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .pins       (pins),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, pins};

endmodule

@@ design/l3bs_csr.sv @@
// APB-style register block holding the phase hold time.
// Depends on l3bs_pkg for the register map and reset value.
`timescale 1ns / 1ps

module l3bs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [l3bs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [l3bs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [l3bs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output logic [15:0]                         phase_hold
);
   import l3bs_pkg::*;

   logic [15:0] hold_ff;
   logic [15:0] hold_in;
   logic [1:0]  reg_index;
   logic        wr_en;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      hold_in = hold_ff;
      if (wr_en && (reg_index == REG_PHASE_HOLD)) begin
         hold_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= PHASE_HOLD_RESET;
      end else begin
         hold_ff <= hold_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_PHASE_HOLD: csr_prdata = {{(CSR_DATA_W-16){1'b0}}, hold_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign phase_hold = hold_ff;

endmodule

@@ design/l3bs_ctrl.sv @@
// Controller state machine: sequences load, drive and hold of each phase.
// Depends on l3bs_pkg for the state, command and status types.
`timescale 1ns / 1ps

module l3bs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  l3bs_pkg::status_type   status,
   output l3bs_pkg::cmd_type      cmd
);
   import l3bs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (status.hold_done && status.out_empty) begin
               state_in = status.is_last ? ST_IDLE : ST_APPLY;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
         end
         ST_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/l3bs_datapath.sv @@
// Datapath: pin levels, shift byte, phase count, hold counter and output register.
// Depends on l3bs_pkg for phase constants and the command and status types.
`timescale 1ns / 1ps

module l3bs_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  l3bs_pkg::cmd_type      cmd,
   output l3bs_pkg::status_type   status,
   input  logic [15:0]            phase_hold,
   input  logic                   action,
   input  logic [7:0]             byte_value,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [2:0]             pins,
   output logic                   rsp_tlast
);
   import l3bs_pkg::*;

   logic       mode_ff, clk_ff, data_ff;
   logic       mode_in, clk_in, data_in;
   logic [7:0] shift_ff, shift_in;
   logic [4:0] phase_ff, phase_in;
   logic       is_data_ff, is_data_in;
   logic [15:0] hold_ff, hold_in;
   logic       valid_ff, valid_in;
   logic       last_ff, last_in;
   logic       phase_last;
   logic [15:0] hold_load;

   assign hold_load  = (phase_hold == 16'd0) ? 16'd0 : phase_hold - 16'd1;
   assign phase_last = is_data_ff ? (phase_ff == PH_DATA_LAST)
                                  : (phase_ff == PH_ADDR_LAST);

   always_comb begin
      mode_in    = mode_ff;
      clk_in     = clk_ff;
      data_in    = data_ff;
      shift_in   = shift_ff;
      phase_in   = phase_ff;
      is_data_in = is_data_ff;
      hold_in    = (hold_ff != 16'd0) ? hold_ff - 16'd1 : hold_ff;
      last_in    = last_ff;
      valid_in   = valid_ff && !rsp_tready;

      if (cmd.start) begin
         shift_in   = byte_value;
         is_data_in = (action == ACT_DATA);
         phase_in   = PH_MODE_START;
      end

      if (cmd.apply) begin
         if (phase_ff == PH_MODE_START) begin
            mode_in = is_data_ff;
         end else if (phase_ff <= PH_LAST_BIT) begin
            if (phase_ff[0]) begin
               clk_in = 1'b1;
            end else begin
               clk_in   = 1'b0;
               data_in  = shift_ff[0];
               shift_in = {1'b0, shift_ff[7:1]};
            end
         end else if (phase_ff == PH_FINAL_CLOCK) begin
            clk_in = 1'b1;
         end else if (is_data_ff && (phase_ff == PH_STROBE_LOW)) begin
            mode_in = 1'b0;
         end else begin
            mode_in = 1'b1;
         end
         last_in  = phase_last;
         phase_in = phase_ff + 5'd1;
         hold_in  = hold_load;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b1;
         clk_ff   <= 1'b1;
         data_ff  <= 1'b1;
         phase_ff <= '0;
         hold_ff  <= '0;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         clk_ff   <= clk_in;
         data_ff  <= data_in;
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      is_data_ff <= is_data_in;
   end

   assign rsp_tvalid       = valid_ff;
   assign rsp_tlast        = last_ff;
   assign pins             = {data_ff, clk_ff, mode_ff};
   assign status.hold_done = (hold_ff == 16'd0);
   assign status.out_empty = !valid_ff;
   assign status.is_last   = last_ff;

   a_apply_into_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> !valid_ff)
      else $error("phase driven while the previous beat is still pending");

   a_apply_shows_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> valid_ff)
      else $error("driven phase did not appear as an output beat");

   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (!valid_ff && (hold_ff == 16'd0)))
      else $error("new byte loaded while a transfer is still active");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= (PH_DATA_LAST + 5'd1))
      else $error("phase count ran past the end of a transfer");

endmodule
